>>> design/cnms_pkg.sv
// Shared types, constants and calendar helpers for the cron next-match search.
// Used by the controller, the datapath and the port checker.
`default_nettype none

package cnms_pkg;

  // Result status codes
  localparam logic [1:0] ST_FOUND      = 2'd0;
  localparam logic [1:0] ST_NOT_LOADED = 2'd1;
  localparam logic [1:0] ST_NO_MATCH   = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_MINUTE  = 3'd0;
  localparam logic [2:0] CFG_HOUR    = 3'd1;
  localparam logic [2:0] CFG_DOM     = 3'd2;
  localparam logic [2:0] CFG_MONTH   = 3'd3;
  localparam logic [2:0] CFG_WEEKDAY = 3'd4;
  localparam logic [2:0] CFG_VALID   = 3'd5;

  // Internal widths: years carry far past 2099 under long searches
  localparam int YEAR_W = 13;
  localparam int DAY_W  = 22;
  localparam int CFG_W  = 60;

  // Epoch anchors (1970-01-01 is a Thursday)
  localparam logic [YEAR_W-1:0] YEAR_BASE  = 13'd1970;
  localparam logic [6:0]        C100_BASE  = 7'd70;
  localparam logic [8:0]        C400_BASE  = 9'd370;
  localparam logic [2:0]        WEEK_BASE  = 3'd4;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DAYS,
    OP_HOUR,
    OP_MIN,
    OP_YEAR,
    OP_MONTH,
    OP_SEARCH,
    OP_FIN1,
    OP_FIN2,
    OP_EMIT_FOUND,
    OP_EMIT_NL,
    OP_EMIT_NM
  } dp_op_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic pattern_valid;
    logic year_done;
    logic month_done;
    logic iter_done;
    logic empty;
    logic found;
  } dp_stat_t;

  // x mod 7 for x < 64, by reciprocal multiply
  function automatic logic [2:0] mod7(input logic [5:0] x);
    logic [11:0] p;
    logic [5:0]  q;
    logic [5:0]  r;
    p = 12'(x) * 12'd37;
    q = {2'b00, p[11:8]};
    r = x - 6'(q * 6'd7);
    return r[2:0];
  endfunction

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mo);
    logic [4:0] n;
    case (mo)
      4'd2: n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

  function automatic logic [8:0] cum_days(input logic [3:0] mo);
    logic [8:0] n;
    case (mo)
      4'd2:  n = 9'd31;
      4'd3:  n = 9'd59;
      4'd4:  n = 9'd90;
      4'd5:  n = 9'd120;
      4'd6:  n = 9'd151;
      4'd7:  n = 9'd181;
      4'd8:  n = 9'd212;
      4'd9:  n = 9'd243;
      4'd10: n = 9'd273;
      4'd11: n = 9'd304;
      4'd12: n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] wd_offset(input logic [3:0] mo);
    logic [2:0] n;
    case (mo)
      4'd2:  n = 3'd3;
      4'd3:  n = 3'd2;
      4'd4:  n = 3'd5;
      4'd5:  n = 3'd0;
      4'd6:  n = 3'd3;
      4'd7:  n = 3'd5;
      4'd8:  n = 3'd1;
      4'd9:  n = 3'd4;
      4'd10: n = 3'd6;
      4'd11: n = 3'd2;
      4'd12: n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

>>> design/cnms_ctrl.sv
// Sequencer for the cron next-match search: conversion, search and output.
// Depends on cnms_pkg (operation codes, status struct).
`default_nettype none

module cnms_ctrl import cnms_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_op_t   op,
  output logic     busy,
  output logic     done
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DAYS   = 10'b0000000010,
    S_HOUR   = 10'b0000000100,
    S_MIN    = 10'b0000001000,
    S_YEAR   = 10'b0000010000,
    S_MONTH  = 10'b0000100000,
    S_SEARCH = 10'b0001000000,
    S_FIN1   = 10'b0010000000,
    S_FIN2   = 10'b0100000000,
    S_EMIT   = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   emit;

  // Next state and datapath command
  always_comb begin
    state_next = state;
    op         = OP_NONE;
    emit       = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (!stat.pattern_valid) begin
            op   = OP_EMIT_NL;
            emit = 1'b1;
          end else begin
            op         = OP_LOAD;
            state_next = S_DAYS;
          end
        end
      end
      S_DAYS: begin
        op         = OP_DAYS;
        state_next = S_HOUR;
      end
      S_HOUR: begin
        op         = OP_HOUR;
        state_next = S_MIN;
      end
      S_MIN: begin
        op         = OP_MIN;
        state_next = S_YEAR;
      end
      S_YEAR: begin
        op = OP_YEAR;
        if (stat.year_done) state_next = S_MONTH;
      end
      S_MONTH: begin
        op = OP_MONTH;
        if (stat.month_done) state_next = S_SEARCH;
      end
      S_SEARCH: begin
        if (stat.iter_done || stat.empty) begin
          op         = OP_EMIT_NM;
          emit       = 1'b1;
          state_next = S_IDLE;
        end else if (stat.found) begin
          state_next = S_FIN1;
        end else begin
          op = OP_SEARCH;
        end
      end
      S_FIN1: begin
        op         = OP_FIN1;
        state_next = S_FIN2;
      end
      S_FIN2: begin
        op         = OP_FIN2;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        op         = OP_EMIT_FOUND;
        emit       = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= emit;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

>>> design/cnms_dp.sv
// Datapath: pattern registers, time split, calendar counters, field search, result.
// Depends on cnms_pkg (widths, codes, calendar helpers).
`default_nettype none

module cnms_dp import cnms_pkg::*; #(
  parameter int ITERATION_LIMIT = 10000
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic [31:0]       start_time,
  input  dp_op_t            op,
  output dp_stat_t          stat,
  output logic [1:0]        status,
  output logic [39:0]       hit_time
);

  localparam int ITER_W = $clog2(ITERATION_LIMIT + 1);

  // Pattern registers
  logic [59:0] minute_mask;
  logic [23:0] hour_mask;
  logic [31:0] dom_mask;
  logic [12:0] month_mask;
  logic [6:0]  weekday_mask;
  logic        pattern_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      minute_mask   <= '0;
      hour_mask     <= '0;
      dom_mask      <= '0;
      month_mask    <= '0;
      weekday_mask  <= '0;
      pattern_valid <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MINUTE:  minute_mask   <= cfg_data[59:0];
        CFG_HOUR:    hour_mask     <= cfg_data[23:0];
        CFG_DOM:     dom_mask      <= cfg_data[31:0];
        CFG_MONTH:   month_mask    <= cfg_data[12:0];
        CFG_WEEKDAY: weekday_mask  <= cfg_data[6:0];
        CFG_VALID:   pattern_valid <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Day 0 and month 0 never match
  logic [31:0] dom_e;
  logic [12:0] mon_e;
  assign dom_e = dom_mask & 32'hFFFF_FFFE;
  assign mon_e = month_mask & 13'h1FFE;

  // Working registers
  logic [31:0]       acc;
  logic [15:0]       dayrem;
  logic [YEAR_W-1:0] y;
  logic [6:0]        c100;
  logic [8:0]        c400;
  logic [2:0]        w;
  logic [DAY_W-1:0]  dby;
  logic [3:0]        mo;
  logic [4:0]        d;
  logic [4:0]        h;
  logic [5:0]        mi;
  logic [ITER_W-1:0] iter;
  logic [DAY_W-1:0]  dsum;
  logic [16:0]       hm;
  logic [39:0]       prod;

  // Leap year from the mod-4/100/400 counters
  logic leap;
  assign leap = ((y[1:0] == 2'd0) && (c100 != 7'd0)) || (c400 == 9'd0);

  // Next-year values
  logic [YEAR_W-1:0] y_p1;
  logic [6:0]        c100_n;
  logic [8:0]        c400_n;
  logic              leap_n;
  logic [2:0]        w_n;
  logic [DAY_W-1:0]  dby_n;
  always_comb begin
    y_p1   = y + 1'b1;
    c100_n = (c100 == 7'd99)  ? 7'd0 : c100 + 7'd1;
    c400_n = (c400 == 9'd399) ? 9'd0 : c400 + 9'd1;
    leap_n = ((y_p1[1:0] == 2'd0) && (c100_n != 7'd0)) || (c400_n == 9'd0);
    w_n    = mod7(6'(w) + 6'd1 + 6'(leap_n));
    dby_n  = dby + DAY_W'(365) + DAY_W'(leap);
  end

  // Time split by reciprocal multiplies: 86400 = 128 * 675, 60 = 4 * 15
  logic [50:0] days_p;
  logic [31:0] sod;
  logic [30:0] tmin_p;
  logic [22:0] hr_p;
  logic [4:0]  hr_c;
  logic [10:0] mi_full;
  always_comb begin
    days_p  = 51'(acc[31:7]) * 51'd50903317;
    sod     = acc - 32'(dayrem) * 32'd86400;
    tmin_p  = 31'(acc[16:2]) * 31'd34953;
    hr_p    = 23'(acc[10:0]) * 23'd2185;
    hr_c    = hr_p[21:17];
    mi_full = acc[10:0] - 11'(hr_c) * 11'd60;
  end

  // Conversion loop bounds
  logic [8:0] year_len;
  logic [4:0] mlen;
  assign year_len = 9'd365 + 9'(leap);
  assign mlen     = month_len(leap, mo);

  // Weekday of the current date
  logic [2:0] w_prev, w_sel, wd;
  always_comb begin
    w_prev = mod7(6'(w) + 6'd6 - 6'(leap));
    w_sel  = (mo < 4'd3) ? w_prev : w;
    wd     = mod7(6'(w_sel) + 6'(wd_offset(mo)) + 6'(d));
  end

  // Next allowed values above the current one and from the bottom
  logic       mon_hi_any, mon_any;
  logic [3:0] mon_hi, mon_lo;
  logic       hr_hi_any, hr_any;
  logic [4:0] hr_hi, hr_lo;
  logic       mi_hi_any, mi_any;
  logic [5:0] mi_hi, mi_lo;
  always_comb begin
    mon_hi_any = 1'b0; mon_hi = '0; mon_lo = '0;
    for (int i = 12; i >= 1; i--) begin
      if (mon_e[i]) mon_lo = 4'(i);
      if (mon_e[i] && (4'(i) > mo)) begin
        mon_hi_any = 1'b1;
        mon_hi     = 4'(i);
      end
    end
    mon_any = |mon_e;
    hr_hi_any = 1'b0; hr_hi = '0; hr_lo = '0;
    for (int i = 23; i >= 0; i--) begin
      if (hour_mask[i]) hr_lo = 5'(i);
      if (hour_mask[i] && (5'(i) > h)) begin
        hr_hi_any = 1'b1;
        hr_hi     = 5'(i);
      end
    end
    hr_any = |hour_mask;
    mi_hi_any = 1'b0; mi_hi = '0; mi_lo = '0;
    for (int i = 59; i >= 0; i--) begin
      if (minute_mask[i]) mi_lo = 6'(i);
      if (minute_mask[i] && (6'(i) > mi)) begin
        mi_hi_any = 1'b1;
        mi_hi     = 6'(i);
      end
    end
    mi_any = |minute_mask;
  end

  // Next calendar day
  logic       ad_last, ad_yinc;
  logic [4:0] ad_d;
  logic [3:0] ad_mo;
  always_comb begin
    ad_last = (d == mlen);
    ad_d    = ad_last ? 5'd1 : d + 5'd1;
    ad_mo   = ad_last ? ((mo == 4'd12) ? 4'd1 : mo + 4'd1) : mo;
    ad_yinc = ad_last && (mo == 4'd12);
  end

  // One search step: test the fields top-down
  logic       s_found, s_empty, s_yinc;
  logic [4:0] s_d, s_h;
  logic [3:0] s_mo;
  logic [5:0] s_mi;
  always_comb begin
    s_found = 1'b0; s_empty = 1'b0; s_yinc = 1'b0;
    s_d = d; s_mo = mo; s_h = h; s_mi = mi;
    if (!mon_e[mo]) begin
      s_d = 5'd1; s_h = '0; s_mi = '0;
      if (mon_hi_any) begin
        s_mo = mon_hi;
      end else if (mon_any) begin
        s_mo   = mon_lo;
        s_yinc = 1'b1;
      end else begin
        s_empty = 1'b1;
      end
    end else if (!dom_e[d] || !weekday_mask[wd]) begin
      s_d = ad_d; s_mo = ad_mo; s_yinc = ad_yinc;
      s_h = '0; s_mi = '0;
    end else if (!hour_mask[h]) begin
      s_mi = '0;
      if (hr_hi_any) begin
        s_h = hr_hi;
      end else if (hr_any) begin
        s_h = hr_lo;
        s_d = ad_d; s_mo = ad_mo; s_yinc = ad_yinc;
      end else begin
        s_empty = 1'b1;
      end
    end else if (!minute_mask[mi]) begin
      if (mi_hi_any) begin
        s_mi = mi_hi;
      end else if (mi_any) begin
        s_mi = mi_lo;
        if (h == 5'd23) begin
          s_h = '0;
          s_d = ad_d; s_mo = ad_mo; s_yinc = ad_yinc;
        end else begin
          s_h = h + 5'd1;
        end
      end else begin
        s_empty = 1'b1;
      end
    end else begin
      s_found = 1'b1;
    end
  end

  logic yinc;
  assign yinc = ((op == OP_YEAR) && (dayrem >= 16'(year_len))) ||
                ((op == OP_SEARCH) && s_yinc);

  // Register updates per command
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        acc  <= start_time;
        iter <= '0;
        y    <= YEAR_BASE;
        c100 <= C100_BASE;
        c400 <= C400_BASE;
        w    <= WEEK_BASE;
        dby  <= '0;
        mo   <= 4'd1;
      end
      // Whole days, then seconds of the day, then minutes of the day
      OP_DAYS: dayrem <= days_p[50:35];
      OP_HOUR: acc    <= sod;
      OP_MIN:  acc    <= 32'(tmin_p[29:19]);
      OP_YEAR: begin
        if (dayrem >= 16'(year_len)) dayrem <= dayrem - 16'(year_len);
        // hour and minute split from the minutes of the day held in acc
        h  <= hr_c;
        mi <= mi_full[5:0];
      end
      OP_MONTH: begin
        if (!stat.month_done) begin
          dayrem <= dayrem - 16'(mlen);
          mo     <= mo + 4'd1;
        end else begin
          d <= dayrem[4:0] + 5'd1;
        end
      end
      OP_SEARCH: begin
        iter <= iter + 1'b1;
        d    <= s_d;
        mo   <= s_mo;
        h    <= s_h;
        mi   <= s_mi;
      end
      OP_FIN1: begin
        dsum <= dby + DAY_W'(cum_days(mo)) + DAY_W'(d) - DAY_W'(1) +
                DAY_W'((mo > 4'd2) && leap);
        hm   <= 17'(h) * 17'd3600 + 17'(mi) * 17'd60;
      end
      OP_FIN2: begin
        prod <= 40'(dsum) * 40'd86400;
      end
      OP_EMIT_FOUND: begin
        status   <= ST_FOUND;
        hit_time <= prod + 40'(hm);
      end
      OP_EMIT_NL: begin
        status   <= ST_NOT_LOADED;
        hit_time <= '0;
      end
      OP_EMIT_NM: begin
        status   <= ST_NO_MATCH;
        hit_time <= '0;
      end
      default: ;
    endcase
    // Year roll: counters, weekday base and day offset move together
    if (yinc) begin
      y    <= y_p1;
      c100 <= c100_n;
      c400 <= c400_n;
      w    <= w_n;
      dby  <= dby_n;
    end
  end

  // Status to the controller
  always_comb begin
    stat.pattern_valid = pattern_valid;
    stat.year_done     = (dayrem < 16'(year_len));
    stat.month_done    = (mo == 4'd12) || (dayrem < 16'(mlen));
    stat.iter_done     = (iter == ITER_W'(ITERATION_LIMIT));
    stat.empty         = s_empty;
    stat.found         = s_found;
  end

endmodule

`default_nettype wire

>>> design/cron_next_match_search.sv
// Top level of the cron next-match search: controller plus datapath.
// Depends on cnms_pkg, cnms_ctrl, cnms_dp.
//
// Usage: load the five field masks and pattern_valid through the write port
// (cfg_we, cfg_index, cfg_data; index 0 minute .. 5 pattern_valid) while idle.
// Pulse start with start_time while busy is low; the request is taken then.
// One result comes back per request: done is high for exactly one cycle with
// status and hit_time valid in that cycle. The receiver cannot stall.
// Sequence: with no pattern loaded, done follows in the cycle after start.
// Otherwise S_DAYS, S_HOUR and S_MIN split the time (reciprocal multiplies),
// S_YEAR steps through the years since 1970, S_MONTH through the months
// before the start month, S_SEARCH takes the field steps of the search
// (bounded by ITERATION_LIMIT), and S_FIN1, S_FIN2 and S_EMIT build the
// seconds value; done is registered from S_EMIT.
// One request at a time; busy stays high until done.
// Reset (rst, synchronous) clears the masks, pattern_valid and the controller.
`default_nettype none

module cron_next_match_search import cnms_pkg::*; #(
  parameter int ITERATION_LIMIT = 10000
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [31:0]       start_time,
  output logic              busy,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  output logic              done,
  output logic [1:0]        status,
  output logic [39:0]       hit_time
);

  dp_op_t   op;
  dp_stat_t stat;

  cnms_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .op    (op),
    .busy  (busy),
    .done  (done)
  );

  cnms_dp #(
    .ITERATION_LIMIT (ITERATION_LIMIT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .start_time (start_time),
    .op         (op),
    .stat       (stat),
    .status     (status),
    .hit_time   (hit_time)
  );

endmodule

`default_nettype wire

>>> design/cnms_checker.sv
// Port-level checks for the cron next-match search, bound to the top level.
// Depends on cnms_pkg (status codes).
`default_nettype none

module cnms_checker import cnms_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [39:0] hit_time
);

  // Only a found result carries a time
  a_time_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_FOUND)) |-> (hit_time == 40'd0))
    else $error("hit_time nonzero without a match");

  // An accepted request either finishes at once or keeps the block busy
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("request accepted but neither busy nor done");

  // The result beat arrives with the block idle again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  // Leaving busy always delivers a result
  a_fall_done: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> done)
    else $error("busy dropped without a result");

endmodule

bind cron_next_match_search cnms_checker u_cnms_checker (.*);

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for cron_next_match_search.
// Drives timestamps against rotating cron masks and checks status and match time
// against an in-bench calendar search. Depends on cnms_pkg and the RTL top.
`default_nettype none

module testbench;
  import cnms_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEARCH_CAP = 10000;
  localparam longint MAX_TIME = 64'd4102444799;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [31:0] start_time = '0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic busy, done;
  logic [1:0] status;
  logic [39:0] hit_time;

  cron_next_match_search #(.ITERATION_LIMIT(SEARCH_CAP)) uut (
    .clk(clk), .rst(rst), .start(start), .start_time(start_time), .busy(busy),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .status(status), .hit_time(hit_time)
  );

  always #10 clk = ~clk;

  typedef struct packed {
    logic [1:0]  st;
    logic [39:0] t;
  } match_beat_t;

  // Predictor copy of the pattern registers
  logic [59:0] pm_min;
  logic [23:0] pm_hour;
  logic [31:0] pm_dom;
  logic [12:0] pm_mon;
  logic [6:0]  pm_wday;
  logic        pm_valid;

  logic [31:0] time_q[$];
  match_beat_t expected_q[$];
  int  errors = 0;
  int  gap_left = 0;

  function automatic bit leap_year(longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint days_to_year(longint y);
    return (y - 1970) * 365 + (y - 1969) / 4 - (y - 1901) / 100 + (y - 1601) / 400;
  endfunction

  function automatic int month_days(longint y, int m);
    int lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m == 2 && leap_year(y)) return 29;
    return lens[m - 1];
  endfunction

  function automatic int weekday_at(longint y, int m, int d);
    int offs[12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
    longint yy;
    yy = y - ((m < 3) ? 1 : 0);
    return int'((yy + yy / 4 - yy / 100 + yy / 400 + offs[m - 1] + d) % 7);
  endfunction

  // Lowest set bit at or above from, -1 when none
  function automatic int lowest_from(logic [63:0] mask, int from);
    for (int i = from; i < 64; i++)
      if (mask[i]) return i;
    return -1;
  endfunction

  function automatic void roll_day(ref longint y, ref int mo, ref int d);
    d++;
    if (d > month_days(y, mo)) begin
      d = 1;
      mo++;
      if (mo > 12) begin
        mo = 1;
        y++;
      end
    end
  endfunction

  // Next matching minute, from the minute that holds t onwards
  function automatic match_beat_t next_match(logic [31:0] t);
    match_beat_t r;
    logic [63:0] mm, hm, dm, mom, wm;
    longint days, rem, y;
    int mo, d, h, mi, nb, cum;
    int cums[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    r.st = ST_NO_MATCH;
    r.t = '0;
    if (!pm_valid) begin
      r.st = ST_NOT_LOADED;
      return r;
    end
    mm = 64'(pm_min);
    hm = 64'(pm_hour);
    dm = 64'(pm_dom) & 64'hFFFF_FFFE;
    mom = 64'(pm_mon) & 64'h1FFE;
    wm = 64'(pm_wday);
    days = longint'(t) / 86400;
    rem = longint'(t) % 86400;
    h = int'(rem / 3600);
    mi = int'((rem % 3600) / 60);
    y = 1970;
    while (days_to_year(y + 1) <= days) y++;
    days -= days_to_year(y);
    mo = 1;
    while (mo < 12 && days >= month_days(y, mo)) begin
      days -= month_days(y, mo);
      mo++;
    end
    d = int'(days) + 1;
    for (int it = 0; it < SEARCH_CAP; it++) begin
      if (!mom[mo]) begin
        nb = lowest_from(mom, mo + 1);
        if (nb < 0) begin
          nb = lowest_from(mom, 0);
          if (nb < 0) return r;
          y++;
        end
        mo = nb; d = 1; h = 0; mi = 0;
        continue;
      end
      if (!dm[d] || !wm[weekday_at(y, mo, d)]) begin
        roll_day(y, mo, d);
        h = 0; mi = 0;
        continue;
      end
      if (!hm[h]) begin
        nb = lowest_from(hm, h + 1);
        if (nb < 0) begin
          nb = lowest_from(hm, 0);
          if (nb < 0) return r;
          roll_day(y, mo, d);
        end
        h = nb; mi = 0;
        continue;
      end
      if (!mm[mi]) begin
        nb = lowest_from(mm, mi + 1);
        if (nb < 0) begin
          nb = lowest_from(mm, 0);
          if (nb < 0) return r;
          h++;
          if (h > 23) begin
            h = 0;
            roll_day(y, mo, d);
          end
        end
        mi = nb;
        continue;
      end
      cum = cums[mo - 1];
      days = days_to_year(y) + cum + (d - 1);
      if (mo > 2 && leap_year(y)) days++;
      r.st = ST_FOUND;
      r.t = 40'(days * 86400 + longint'(h) * 3600 + longint'(mi) * 60);
      return r;
    end
    return r;
  endfunction

  // Driver: one beat per accepted start, random gaps between beats
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      // beat taken at this edge
      expected_q.push_back(next_match(start_time));
      if (time_q.size() > 0 && $urandom_range(0, 3) == 0) begin
        start_time <= time_q.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
        gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 3);
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (time_q.size() > 0) begin
        start_time <= time_q.pop_front();
        start <= 1'b1;
      end
    end
  end

  // Monitor: every done beat is checked against the oldest prediction
  always @(posedge clk) begin
    match_beat_t e;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d hit_time=%0d", $time, status, hit_time);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, status);
          errors++;
        end
        if (hit_time !== e.t) begin
          $display("%0t: hit_time expected %0d actual %0d", $time, e.t, hit_time);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MINUTE:  pm_min = val[59:0];
      CFG_HOUR:    pm_hour = val[23:0];
      CFG_DOM:     pm_dom = val[31:0];
      CFG_MONTH:   pm_mon = val[12:0];
      CFG_WEEKDAY: pm_wday = val[6:0];
      CFG_VALID:   pm_valid = val[0];
      default: ;
    endcase
  endtask

  task automatic load_pattern(logic [59:0] mi, logic [23:0] h, logic [31:0] dm,
                              logic [12:0] mo, logic [6:0] wd, logic v);
    write_reg(CFG_MINUTE, mi);
    write_reg(CFG_HOUR, 60'(h));
    write_reg(CFG_DOM, 60'(dm));
    write_reg(CFG_MONTH, 60'(mo));
    write_reg(CFG_WEEKDAY, 60'(wd));
    write_reg(CFG_VALID, 60'(v));
  endtask

  // Wait for the block to drain completely
  task automatic drain();
    while (time_q.size() > 0 || start || busy || expected_q.size() > 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_time();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 32'hFFFF_FFFF);
      1: return 32'(longint'($urandom_range(0, 32'hFFFF_FFFF)) % (MAX_TIME + 1));
      2: return $urandom_range(0, 200000);
      3: return 32'(MAX_TIME) - $urandom_range(0, 100000000);
      default: return $urandom_range(1500000000, 2000000000);
    endcase
  endfunction

  // Random but dense-enough pattern
  function automatic logic [59:0] rand_mask(int w, int style);
    logic [59:0] m;
    m = 60'({$urandom(), $urandom()});
    case (style)
      0: m = '1;
      1: m = 60'(1) << $urandom_range(0, w - 1);
      2: m = m & 60'({$urandom(), $urandom()});
      default: ;
    endcase
    if (w < 60) m = m & ((60'(1) << w) - 60'(1));
    return m;
  endfunction

  initial begin
    logic [31:0] directed[$];
    pm_min = '0; pm_hour = '0; pm_dom = '0; pm_mon = '0; pm_wday = '0; pm_valid = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Not loaded: status only
    time_q.push_back(32'd0);
    time_q.push_back(32'hFFFF_FFFF);
    drain();

    // Every minute allowed: the minute of the start itself matches
    load_pattern('1, '1, '1, '1, '1, 1'b1);
    directed = '{32'd0, 32'd59, 32'd86399, 32'd951782400, 32'd4102444799,
                 32'hFFFF_FFFF, 32'd1709164800};
    foreach (directed[i]) time_q.push_back(directed[i]);
    drain();

    // Day 29 of February or December, on Sunday only; ignored mask bits set
    load_pattern(60'h1 | 60'h8000_0000_0000_000, 24'h1, 32'h2000_0001, 13'h1005, 7'h01, 1'b1);
    time_q.push_back(32'd0);
    time_q.push_back(32'd1700000000);
    drain();

    // Empty masks: month, hour, minute give immediate no match, weekday runs the cap
    load_pattern('0, '1, '1, '1, '1, 1'b1);
    time_q.push_back(32'd12345);
    drain();
    load_pattern('1, '0, '1, '1, '1, 1'b1);
    time_q.push_back(32'd12345);
    drain();
    load_pattern('1, '1, '1, 13'h0001, '1, 1'b1);
    time_q.push_back(32'd12345);
    drain();
    load_pattern('1, '1, '1, '1, 7'h0, 1'b1);
    time_q.push_back(32'd12345);
    drain();

    // Wraps at minute, hour, month and year boundaries
    load_pattern(60'h1, 24'h1, 32'h2, 13'h2, '1, 1'b1);
    time_q.push_back(32'd1703980799);
    time_q.push_back(32'd4102444799);
    drain();

    // Random phases
    for (int ph = 0; ph < 62; ph++) begin
      load_pattern(rand_mask(60, $urandom_range(0, 3)),
                   24'(rand_mask(24, $urandom_range(0, 3))),
                   (ph % 3 == 0) ? 32'hFFFF_FFFF : 32'(rand_mask(32, $urandom_range(0, 3))),
                   (ph % 4 == 0) ? 13'h1FFF : 13'(rand_mask(13, $urandom_range(0, 3))),
                   (ph % 2 == 0) ? 7'h7F : 7'(rand_mask(7, $urandom_range(0, 3))),
                   (ph % 20 != 7));
      for (int i = 0; i < 25; i++) time_q.push_back(rand_time());
      drain();
    end
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("** cron_next_match_search: PASSED **");
    end else begin
      $display("** cron_next_match_search: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000ms;
    $display("** cron_next_match_search: FAILED **");
    $finish;
  end
endmodule

`default_nettype wire

>>> sim.f
design/cnms_pkg.sv
design/cnms_ctrl.sv
design/cnms_dp.sv
design/cron_next_match_search.sv
design/cnms_checker.sv
dv/testbench.sv
